[sv/irqlh_pkg.sv]
// ============================================================================
// irqlh_pkg
// Shared constants, types and helpers for the interrupt latency histogram
// monitor.
// ============================================================================
package irqlh_pkg;

    localparam int NUM_BUCKETS = 16;
    localparam int TIME_BITS   = 48;
    localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
    localparam int CNT_W       = 32;
    localparam int PEAK_W      = 48;
    localparam int SUM_W       = 56;
    localparam int IDX_W       = 4;
    localparam int OP_W        = 3;
    localparam int TS_W        = 48;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [OP_W-1:0] OP_RAISE   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
    localparam logic [OP_W-1:0] OP_DELIVER = 3'd2;
    localparam logic [OP_W-1:0] OP_READ    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLR_ST  = 3'd4;

    localparam logic [2:0] ADDR_ENABLE = 3'd0;

    // One request after the pending-line stage, on its way to the statistics.
    typedef struct packed {
        logic                 clr_stats;
        logic                 lost_inc;
        logic                 got;
        logic [TIME_BITS-1:0] lat;
        logic [IDX_W-1:0]     idx;
        logic                 pending;
    } t_event;

    // Statistics as they stand after a request.
    typedef struct packed {
        logic [CNT_W-1:0]  bucket_count;
        logic [CNT_W-1:0]  delivered;
        logic [CNT_W-1:0]  lost;
        logic [PEAK_W-1:0] peak;
        logic [SUM_W-1:0]  sum;
    } t_view;

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [TIME_BITS-1:0] lat);
        int len;
        len = 0;
        for (int i = 0; i < TIME_BITS; i++) begin
            if (lat[i]) begin
                len = i + 1;
            end
        end
        if (len > NUM_BUCKETS - 1) begin
            len = NUM_BUCKETS - 1;
        end
        return BUCKET_W'(len);
    endfunction

endpackage

[sv/irqlh_stats.sv]
// ============================================================================
// irqlh_stats
// Histogram and running totals; updated once per request and presenting the
// values that hold after it.
// ============================================================================
module irqlh_stats (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd,
    input  irqlh_pkg::t_event i_evt,
    output irqlh_pkg::t_view  o_view
);

    localparam int ADD_W = ((irqlh_pkg::SUM_W > irqlh_pkg::TIME_BITS) ?
                            irqlh_pkg::SUM_W : irqlh_pkg::TIME_BITS) + 1;

    logic [irqlh_pkg::CNT_W-1:0]  r_hist [irqlh_pkg::NUM_BUCKETS];
    logic [irqlh_pkg::CNT_W-1:0]  n_hist [irqlh_pkg::NUM_BUCKETS];
    logic [irqlh_pkg::CNT_W-1:0]  r_deliv, n_deliv;
    logic [irqlh_pkg::CNT_W-1:0]  r_lost, n_lost;
    logic [irqlh_pkg::PEAK_W-1:0] r_peak, n_peak;
    logic [irqlh_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [irqlh_pkg::BUCKET_W-1:0] bucket;
    logic [ADD_W-1:0]             sum_wide;
    logic [irqlh_pkg::PEAK_W-1:0] lat_peak;
    logic [irqlh_pkg::CNT_W-1:0]  rd_count;

    always_comb begin
        bucket   = irqlh_pkg::bucket_of(i_evt.lat);
        sum_wide = ADD_W'(r_sum) + ADD_W'(i_evt.lat);
        lat_peak = irqlh_pkg::PEAK_W'(i_evt.lat);
        for (int i = 0; i < irqlh_pkg::NUM_BUCKETS; i++) begin
            n_hist[i] = r_hist[i];
            if (i_evt.clr_stats) begin
                n_hist[i] = '0;
            end else if (i_evt.got && bucket == irqlh_pkg::BUCKET_W'(i) &&
                         r_hist[i] != irqlh_pkg::CNT_MAX) begin
                n_hist[i] = r_hist[i] + 1'b1;
            end
        end
        n_deliv = r_deliv;
        n_lost  = r_lost;
        n_peak  = r_peak;
        n_sum   = r_sum;
        if (i_evt.clr_stats) begin
            n_deliv = '0;
            n_lost  = '0;
            n_peak  = '0;
            n_sum   = '0;
        end else begin
            if (i_evt.lost_inc && r_lost != irqlh_pkg::CNT_MAX) begin
                n_lost = r_lost + 1'b1;
            end
            if (i_evt.got) begin
                if (r_deliv != irqlh_pkg::CNT_MAX) begin
                    n_deliv = r_deliv + 1'b1;
                end
                if (sum_wide > ADD_W'(irqlh_pkg::SUM_MAX)) begin
                    n_sum = irqlh_pkg::SUM_MAX;
                end else begin
                    n_sum = irqlh_pkg::SUM_W'(sum_wide);
                end
                if (lat_peak > r_peak) begin
                    n_peak = lat_peak;
                end
            end
        end
        rd_count = '0;
        for (int i = 0; i < irqlh_pkg::NUM_BUCKETS; i++) begin
            if (32'(i_evt.idx) == i) begin
                rd_count = n_hist[i];
            end
        end
        o_view.bucket_count = rd_count;
        o_view.delivered    = n_deliv;
        o_view.lost         = n_lost;
        o_view.peak         = n_peak;
        o_view.sum          = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < irqlh_pkg::NUM_BUCKETS; i++) begin
                r_hist[i] <= '0;
            end
            r_deliv <= '0;
            r_lost  <= '0;
            r_peak  <= '0;
            r_sum   <= '0;
        end else if (i_upd) begin
            for (int i = 0; i < irqlh_pkg::NUM_BUCKETS; i++) begin
                r_hist[i] <= n_hist[i];
            end
            r_deliv <= n_deliv;
            r_lost  <= n_lost;
            r_peak  <= n_peak;
            r_sum   <= n_sum;
        end
    end

endmodule

[sv/irq_latency_histogram_monitor.sv]
// ============================================================================
// irq_latency_histogram_monitor
// Measures raise-to-delivery latency of an interrupt line and keeps a log2
// histogram with saturating totals.
// ============================================================================
//  Channel   Direction  Handshake               Contents
//  s_axis    in         tvalid/tready           opcode, timestamp, bucket_index
//  m_axis    out        tvalid/tready           statistics after the request
//  apb       in/out     psel/penable/pready     enable register at address 0
//
// Each request passes through a pending-line stage then the statistics
// stage feeding the result register. A new request is accepted every cycle
// while results are taken. The result register is the skid point: input
// stalls only when a result and a staged request both wait. Reset clears
// the pending line, histogram and totals and disables the block.
module irq_latency_histogram_monitor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] opcode, [50:3] timestamp, [54:51] bucket_index, [55] zero
    input  logic [55:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] bucket_count, [63:32] delivered_count, [95:64] lost_count,
    // [143:96] max_latency, [199:144] total_latency,
    // [247:200] measured_latency, [248] line_pending, [255:249] zero
    output logic [255:0] m_axis_tdata,
    // [0] measured
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int TB = irqlh_pkg::TIME_BITS;

    logic                  r_enable;
    logic [TB-1:0]         r_pend, n_pend;
    logic                  r_s1_valid;
    irqlh_pkg::t_event     r_s1, n_s1;
    logic                  r_m_valid;
    logic [255:0]          r_m_data;
    logic                  r_m_user;
    irqlh_pkg::t_view      view;

    logic                  out_free;
    logic                  s1_adv;
    logic                  accept;
    logic [irqlh_pkg::OP_W-1:0] op;
    logic [TB-1:0]         ts;
    logic                  busy;

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign pready        = 1'b1;
    assign prdata        = (paddr == irqlh_pkg::ADDR_ENABLE) ? {31'd0, r_enable} : 32'd0;

    always_comb begin
        op    = s_axis_tdata[2:0];
        ts    = TB'(s_axis_tdata[50:3]);
        busy  = r_enable && r_pend != '0;
        n_pend = r_pend;
        n_s1.clr_stats = 1'b0;
        n_s1.lost_inc  = 1'b0;
        n_s1.got       = 1'b0;
        n_s1.lat       = '0;
        n_s1.idx       = s_axis_tdata[54:51];
        case (op)
            irqlh_pkg::OP_RAISE: begin
                if (r_enable && r_pend == '0) begin
                    n_pend = (ts == '0) ? TB'(1) : ts;
                end
            end
            irqlh_pkg::OP_CLEAR: begin
                if (busy) begin
                    n_s1.lost_inc = 1'b1;
                    n_pend        = '0;
                end
            end
            irqlh_pkg::OP_DELIVER: begin
                if (busy) begin
                    n_s1.got = 1'b1;
                    n_s1.lat = (ts > r_pend) ? ts - r_pend : '0;
                    n_pend   = '0;
                end
            end
            irqlh_pkg::OP_CLR_ST: begin
                n_s1.clr_stats = 1'b1;
                n_pend         = '0;
            end
            default: begin
            end
        endcase
        n_s1.pending = n_pend != '0;
    end

    irqlh_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (s1_adv),
        .i_evt   (r_s1),
        .o_view  (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_pend     <= '0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == irqlh_pkg::ADDR_ENABLE) begin
                r_enable <= pwdata[0];
            end
            if (accept) begin
                r_pend     <= n_pend;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_m_data <= {7'd0, r_s1.pending, 48'(r_s1.lat), view.sum, view.peak,
                         view.lost, view.delivered, view.bucket_count};
            r_m_user <= r_s1.got;
        end
    end

endmodule

[verif/irqlh_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// irqlh_checker
// Watches the request, result and register channels of the interrupt latency
// histogram monitor. It keeps its own copy of the pending line, histogram and
// totals, works out the statistics that each accepted request should report,
// and compares every accepted result with the oldest outstanding one.
// ============================================================================
module irqlh_checker
    import irqlh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // [2:0] opcode, [50:3] timestamp, [54:51] bucket_index, [55] zero
    input  logic [55:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] bucket_count, [63:32] delivered_count, [95:64] lost_count,
    // [143:96] max_latency, [199:144] total_latency,
    // [247:200] measured_latency, [248] line_pending, [255:249] zero
    input  logic [255:0] m_axis_tdata,
    // [0] measured
    input  logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_pending_results,
    output int           o_error_count
);

    typedef struct packed {
        logic [CNT_W-1:0]     bucket_count;
        logic [CNT_W-1:0]     delivered_count;
        logic [CNT_W-1:0]     lost_count;
        logic [PEAK_W-1:0]    max_latency;
        logic [SUM_W-1:0]     total_latency;
        logic [TIME_BITS-1:0] measured_latency;
        logic                 measured;
        logic                 line_pending;
    } t_line_stats;

    logic [TIME_BITS-1:0] raised_at;
    logic [CNT_W-1:0]     bucket_hits [NUM_BUCKETS];
    logic [CNT_W-1:0]     deliveries;
    logic [CNT_W-1:0]     losses;
    logic [PEAK_W-1:0]    worst_latency;
    logic [SUM_W-1:0]     latency_total;
    logic                 armed;
    t_line_stats          stats_due [$];
    int                   errors;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic wipe_stats();
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            bucket_hits[i] = '0;
        end
        deliveries    = '0;
        losses        = '0;
        worst_latency = '0;
        latency_total = '0;
        raised_at     = '0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_line_stats          want;
        t_line_stats          seen;
        logic [OP_W-1:0]      op;
        logic [TS_W-1:0]      ts;
        logic [IDX_W-1:0]     idx;
        logic [TIME_BITS-1:0] lat;
        logic [TIME_BITS-1:0] rest;
        int                   bucket;

        if (!i_rst_n) begin
            wipe_stats();
            armed = 1'b0;
            stats_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ENABLE) begin
                armed = pwdata[0];
            end

            if (m_axis_tvalid && m_axis_tready) begin
                seen.bucket_count     = m_axis_tdata[31:0];
                seen.delivered_count  = m_axis_tdata[63:32];
                seen.lost_count       = m_axis_tdata[95:64];
                seen.max_latency      = m_axis_tdata[143:96];
                seen.total_latency    = m_axis_tdata[199:144];
                seen.measured_latency = m_axis_tdata[247:200];
                seen.line_pending     = m_axis_tdata[248];
                seen.measured         = m_axis_tuser[0];
                if (stats_due.size() == 0) begin
                    $error("Result delivered with no request outstanding.");
                    errors++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("bucket_count", 64'(want.bucket_count),
                                64'(seen.bucket_count));
                    check_field("delivered_count", 64'(want.delivered_count),
                                64'(seen.delivered_count));
                    check_field("lost_count", 64'(want.lost_count),
                                64'(seen.lost_count));
                    check_field("max_latency", 64'(want.max_latency),
                                64'(seen.max_latency));
                    check_field("total_latency", 64'(want.total_latency),
                                64'(seen.total_latency));
                    check_field("measured_latency", 64'(want.measured_latency),
                                64'(seen.measured_latency));
                    check_field("measured", 64'(want.measured), 64'(seen.measured));
                    check_field("line_pending", 64'(want.line_pending),
                                64'(seen.line_pending));
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                op   = s_axis_tdata[2:0];
                ts   = s_axis_tdata[50:3];
                idx  = s_axis_tdata[54:51];
                lat  = '0;
                want.measured = 1'b0;
                case (op)
                    OP_RAISE: begin
                        if (armed && raised_at == '0) begin
                            raised_at = (ts == '0) ? TIME_BITS'(1) : ts;
                        end
                    end
                    OP_CLEAR: begin
                        if (armed && raised_at != '0) begin
                            losses    = bump(losses);
                            raised_at = '0;
                        end
                    end
                    OP_DELIVER: begin
                        if (armed && raised_at != '0) begin
                            lat    = (ts > raised_at) ? ts - raised_at : '0;
                            rest   = lat;
                            bucket = 0;
                            while (rest != '0 && bucket < NUM_BUCKETS - 1) begin
                                rest = rest >> 1;
                                bucket++;
                            end
                            bucket_hits[bucket] = bump(bucket_hits[bucket]);
                            deliveries = bump(deliveries);
                            if (SUM_W'(lat) > SUM_MAX - latency_total) begin
                                latency_total = SUM_MAX;
                            end else begin
                                latency_total = latency_total + SUM_W'(lat);
                            end
                            if (lat > worst_latency) begin
                                worst_latency = lat;
                            end
                            want.measured = 1'b1;
                            raised_at     = '0;
                        end
                    end
                    OP_CLR_ST: begin
                        wipe_stats();
                    end
                    default: begin
                    end
                endcase
                want.bucket_count     = bucket_hits[idx];
                want.delivered_count  = deliveries;
                want.lost_count       = losses;
                want.max_latency      = worst_latency;
                want.total_latency    = latency_total;
                want.measured_latency = lat;
                want.line_pending     = (raised_at != '0);
                stats_due.push_back(want);
            end
        end
        o_pending_results <= stats_due.size();
        o_error_count     <= errors;
    end

endmodule

[verif/tb_irq_latency_histogram_monitor.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_irq_latency_histogram_monitor
// Drives raise, clear, deliver, read and clear-statistics requests into the
// interrupt latency histogram monitor under several enable settings, with
// random gaps and back-pressure, and a long run that drives the latency total
// into saturation. Checking is done by irqlh_checker.
// ============================================================================
module tb_irq_latency_histogram_monitor;
    import irqlh_pkg::*;

    localparam int              WATCHDOG_LIMIT = 1000;
    localparam logic [TS_W-1:0] TS_TOP         = '1;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [2:0] opcode, [50:3] timestamp, [54:51] bucket_index, [55] zero
    logic [55:0]  s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] bucket_count, [63:32] delivered_count, [95:64] lost_count,
    // [143:96] max_latency, [199:144] total_latency,
    // [247:200] measured_latency, [248] line_pending, [255:249] zero
    logic [255:0] m_axis_tdata;
    // [0] measured
    logic [0:0]   m_axis_tuser;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [2:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    logic         steady        = 1'b0;
    int           pending_results;
    int           error_count;
    int           quiet_cycles  = 0;

    irq_latency_histogram_monitor u_top (.*);

    irqlh_checker u_checker (
        .*,
        .o_pending_results(pending_results),
        .o_error_count(error_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99, 0) >= 9);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_irq_latency_histogram_monitor failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [TS_W-1:0] rand_ts();
        return TS_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TS_W-1:0] rand_span();
        return rand_ts() >> $urandom_range(TS_W - 1, 0);
    endfunction

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom);
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts,
                            input logic [IDX_W-1:0] idx);
        if (!steady && $urandom_range(99, 0) < 9) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, idx, ts, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly complete raise-then-deliver or raise-then-clear sequences, with
    // stray reads and repeated raises in between, and some random noise.
    task automatic run_traffic(input int n_items);
        int              sent;
        logic [TS_W-1:0] t0;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99, 0) < 80) begin
                t0 = rand_ts();
                send_req(OP_RAISE, t0, rand_idx());
                sent++;
                repeat ($urandom_range(2, 0)) begin
                    send_req(($urandom_range(1, 0) != 0) ? OP_READ : OP_RAISE,
                             rand_ts(), rand_idx());
                    sent++;
                end
                case ($urandom_range(9, 0))
                    0, 1: send_req(OP_CLEAR, rand_ts(), rand_idx());
                    2: send_req(OP_DELIVER, t0 - rand_span(), rand_idx());
                    default: send_req(OP_DELIVER, t0 + rand_span(), rand_idx());
                endcase
                sent++;
            end else begin
                send_req(OP_W'($urandom_range(7, 0)), rand_ts(), rand_idx());
                sent++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block comes out of reset disabled, so these change nothing.
        send_req(OP_RAISE, TS_W'(100), '0);
        send_req(OP_DELIVER, TS_W'(200), '0);
        send_req(OP_CLEAR, '0, '0);
        settle();
        apb_write(ADDR_ENABLE, 32'h1);

        send_req(OP_RAISE, '0, '0);
        send_req(OP_RAISE, TS_TOP, '0);
        send_req(OP_DELIVER, '0, '0);
        send_req(OP_RAISE, TS_TOP, '1);
        send_req(OP_DELIVER, TS_W'(5), '0);
        send_req(OP_RAISE, TS_W'(1000), '0);
        send_req(OP_CLEAR, '0, '0);
        send_req(OP_CLEAR, '0, '0);
        send_req(OP_DELIVER, TS_W'(2000), '0);
        send_req(OP_RAISE, TS_W'(1), '0);
        send_req(OP_DELIVER, TS_TOP, '1);
        send_req(OP_RAISE, TS_W'(10), IDX_W'(1));
        send_req(OP_DELIVER, TS_W'(11), IDX_W'(1));
        send_req(OP_READ, TS_TOP, '0);
        send_req(OP_READ, rand_ts(), '1);
        send_req(OP_READ, rand_ts(), IDX_W'(7));
        for (int k = 5; k < 8; k++) begin
            send_req(OP_W'(k), rand_ts(), rand_idx());
        end
        send_req(OP_RAISE, TS_W'(42), '0);
        send_req(OP_CLR_ST, '0, '0);
        send_req(OP_READ, '0, '1);

        run_traffic(40);
        settle();
        apb_write(ADDR_ENABLE, 32'hFFFF_FFFE);
        run_traffic(10);
        settle();
        apb_write(ADDR_ENABLE, 32'hFFFF_FFFF);

        // Near full-range latencies, enough of them to saturate the total.
        steady <= 1'b1;
        for (int k = 0; k < 260; k++) begin
            if (k == 130) begin
                steady <= 1'b0;
            end
            send_req(OP_RAISE, TS_W'($urandom_range(3, 0)), rand_idx());
            send_req(OP_DELIVER, TS_TOP - TS_W'($urandom_range(3, 0)), rand_idx());
        end
        send_req(OP_READ, rand_ts(), '1);
        run_traffic(20);

        settle();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_irq_latency_histogram_monitor passed");
        end else begin
            $display("tb_irq_latency_histogram_monitor failed");
        end
        $finish;
    end

endmodule
